// File: hw/rtl/ufrm_pkg.sv
// Shared types, constants and helpers for the frame receiver mailbox.
// Used by the channel interfaces, the core and its front and back ends; no dependencies.
package ufrm_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int IDX_W = $clog2(MAX_PAYLOAD);
   localparam int LEN_W = 6;
   localparam int BYTE_INDEX_W = 5;
   localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
   localparam int RAM_ADDR_W = IDX_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD);

   // Item command codes on the request channel.
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_DISCARD = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_FIRST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0] HEADER_FIRST_RESET = 8'd170;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'd85;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_TICK,
      KIND_READ,
      KIND_DISCARD
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [15:0] timeout_ticks;
   } cfg_type;

   function automatic kind_type decode_cmd(logic [1:0] cmd);
      kind_type kind;
      case (cmd)
         CMD_BYTE: kind = KIND_BYTE;
         CMD_TICK: kind = KIND_TICK;
         CMD_READ: kind = KIND_READ;
         CMD_DISCARD: kind = KIND_DISCARD;
         default: kind = KIND_BYTE;
      endcase
      return kind;
   endfunction

endpackage

// File: hw/rtl/ufrm_channels.sv
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on ufrm_pkg for field widths.
interface ufrm_req_if;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface ufrm_rsp_if;
   logic valid;
   logic ready;
   logic frame_valid;
   logic [7:0] command;
   logic [ufrm_pkg::LEN_W-1:0] length;
   logic [7:0] payload_byte;
   logic [ufrm_pkg::BYTE_INDEX_W-1:0] byte_index;
   logic last_item;
   modport source (output valid, output frame_valid, output command, output length,
                   output payload_byte, output byte_index, output last_item, input ready);
   modport sink (input valid, input frame_valid, input command, input length,
                 input payload_byte, input byte_index, input last_item, output ready);
endinterface

interface ufrm_csr_if;
   logic valid;
   logic ready;
   logic [ufrm_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [ufrm_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hw/rtl/uart_frame_receiver_mailbox_core.sv
// A byte, tick or discard transaction is queued and updates the parser state when the back end
// takes it. A read of an empty mailbox or empty payload loads the response register directly;
// a payload is first read from the RAM, then sent one byte per cycle while the receiver is ready.
// Throughput: one request per cycle is accepted into a two-entry queue while it has room; the back
// end retires one non-read item per cycle except while a read of a payload drains the mailbox.
// Reset is synchronous and active high; it clears all control state, no memory clearing pass.
module uart_frame_receiver_mailbox_core (
   input  logic clock,
   input  logic reset,
   ufrm_req_if.sink req_bus,
   ufrm_rsp_if.source rsp_bus,
   ufrm_csr_if.sink csr_bus
);

   // Configuration registers. The user must write them only while the block is idle; the block
   // does not enforce it, and writes are applied directly without any handoff to the back end.
   ufrm_pkg::cfg_type cfg_ff;
   ufrm_pkg::cfg_type cfg_in;

   // Front-to-back queue head and pop handshake.
   logic q_valid;
   ufrm_pkg::item_type q_item;
   logic q_pop;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            ufrm_pkg::REG_HEADER_FIRST: cfg_in.header_first = csr_bus.wdata[7:0];
            ufrm_pkg::REG_HEADER_SECOND: cfg_in.header_second = csr_bus.wdata[7:0];
            ufrm_pkg::REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_bus.wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first <= ufrm_pkg::HEADER_FIRST_RESET;
         cfg_ff.header_second <= ufrm_pkg::HEADER_SECOND_RESET;
         cfg_ff.timeout_ticks <= ufrm_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end accepts and classifies transactions into a short queue,
   // so a stalled response channel never blocks request acceptance directly.
   ufrm_front u_front (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   // The back end runs the parser, owns the mailbox and drains it on reads.
   // Payload bytes live in a two-bank RAM; a good frame hands its bank to the
   // mailbox instead of being copied.
   ufrm_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .rsp(rsp_bus)
   );

endmodule

// File: hw/rtl/ufrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/ufrm_front.sv
// Front end: accepts request transactions, classifies them and queues them.
// Depends on ufrm_pkg and ufrm_req_if.
module ufrm_front (
   input  logic clock,
   input  logic reset,
   ufrm_req_if.sink req,
   output logic q_valid,
   output ufrm_pkg::item_type q_item,
   input  logic q_pop
);

   ufrm_pkg::item_type slot_ff [ufrm_pkg::QUEUE_DEPTH];
   logic wr_ptr_ff;
   logic wr_ptr_in;
   logic rd_ptr_ff;
   logic rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic push;
   logic pop;

   assign req.ready = (count_ff != 2'(ufrm_pkg::QUEUE_DEPTH));
   assign push = req.valid && req.ready;
   assign pop = q_pop && q_valid;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{kind: ufrm_pkg::decode_cmd(req.cmd), data: req.data_byte};
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // The pointers differ exactly when one entry is held.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with the entry count");

endmodule

// File: hw/rtl/ufrm_back.sv
// Back end: frame parser, one-frame mailbox and the read-out sequencer.
// Depends on ufrm_pkg, ufrm_rsp_if and ufrm_ram.
module ufrm_back (
   input  logic clock,
   input  logic reset,
   input  ufrm_pkg::cfg_type cfg,
   input  logic q_valid,
   input  ufrm_pkg::item_type q_item,
   output logic q_pop,
   ufrm_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_LEN,
      PH_CMD,
      PH_DATA,
      PH_SUM
   } phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   localparam int LW = ufrm_pkg::LEN_W;
   localparam int IW = ufrm_pkg::IDX_W;
   localparam int AW = ufrm_pkg::RAM_ADDR_W;

   phase_type phase_ff, phase_in;
   state_type state_ff, state_in;
   logic [LW-1:0] exp_len_ff, exp_len_in;
   logic [7:0] cmd_hold_ff, cmd_hold_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [7:0] sum_ff, sum_in;
   logic [15:0] idle_ff, idle_in;
   logic rx_bank_ff, rx_bank_in;
   logic mb_bank_ff, mb_bank_in;
   logic mb_full_ff, mb_full_in;
   logic [7:0] mb_cmd_ff, mb_cmd_in;
   logic [LW-1:0] mb_len_ff, mb_len_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   logic out_valid_ff, out_valid_in;
   logic out_fvalid_ff, out_fvalid_in;
   logic [7:0] out_cmd_ff, out_cmd_in;
   logic [LW-1:0] out_len_ff, out_len_in;
   logic [7:0] out_data_ff, out_data_in;
   logic [ufrm_pkg::BYTE_INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic out_last_ff, out_last_in;

   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0] ram_rdata;

   logic slot_free;
   logic restart;
   logic restart_hdr;
   logic [7:0] b;
   logic [LW-1:0] fill_next;
   logic [LW-1:0] rd_next;
   logic [15:0] idle_sat;

   ufrm_ram #(
      .WIDTH(8),
      .DEPTH(ufrm_pkg::RAM_DEPTH)
   ) u_payload_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(b),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign b = q_item.data;
   assign slot_free = !out_valid_ff || rsp.ready;
   assign fill_next = fill_ff + LW'(1);
   assign rd_next = LW'(rd_idx_ff) + LW'(1);
   assign idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      state_in = state_ff;
      exp_len_in = exp_len_ff;
      cmd_hold_in = cmd_hold_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      idle_in = idle_ff;
      rx_bank_in = rx_bank_ff;
      mb_bank_in = mb_bank_ff;
      mb_full_in = mb_full_ff;
      mb_cmd_in = mb_cmd_ff;
      mb_len_in = mb_len_ff;
      rd_idx_in = rd_idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_fvalid_in = out_fvalid_ff;
      out_cmd_in = out_cmd_ff;
      out_len_in = out_len_ff;
      out_data_in = out_data_ff;
      out_idx_in = out_idx_ff;
      out_last_in = out_last_ff;
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = {rx_bank_ff, fill_ff[IW-1:0]};
      ram_re = 1'b0;
      ram_raddr = {mb_bank_ff, {IW{1'b0}}};
      restart = 1'b0;
      restart_hdr = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.kind)
                  ufrm_pkg::KIND_BYTE: begin
                     q_pop = 1'b1;
                     idle_in = 16'd0;
                     case (phase_ff)
                        PH_HUNT1: begin
                           if (b == cfg.header_first) begin
                              phase_in = PH_HUNT2;
                           end
                        end
                        PH_HUNT2: begin
                           if (b == cfg.header_second) begin
                              phase_in = PH_LEN;
                           end else begin
                              restart = 1'b1;
                              restart_hdr = (b == cfg.header_first);
                           end
                        end
                        PH_LEN: begin
                           if (b > ufrm_pkg::LEN_LIMIT) begin
                              restart = 1'b1;
                              restart_hdr = (b == cfg.header_first);
                           end else begin
                              exp_len_in = b[LW-1:0];
                              fill_in = '0;
                              sum_in = b;
                              phase_in = PH_CMD;
                           end
                        end
                        PH_CMD: begin
                           cmd_hold_in = b;
                           sum_in = sum_ff + b;
                           phase_in = (exp_len_ff == '0) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA: begin
                           ram_we = 1'b1;
                           sum_in = sum_ff + b;
                           fill_in = fill_next;
                           if (fill_next >= exp_len_ff) begin
                              phase_in = PH_SUM;
                           end
                        end
                        PH_SUM: begin
                           // A good frame takes an empty mailbox by swapping banks.
                           if (b == sum_ff && !mb_full_ff) begin
                              mb_cmd_in = cmd_hold_ff;
                              mb_len_in = exp_len_ff;
                              mb_bank_in = rx_bank_ff;
                              rx_bank_in = !rx_bank_ff;
                              mb_full_in = 1'b1;
                           end
                           restart = 1'b1;
                        end
                        default: begin
                           restart = 1'b1;
                        end
                     endcase
                  end
                  ufrm_pkg::KIND_TICK: begin
                     q_pop = 1'b1;
                     if (phase_ff != PH_HUNT1) begin
                        idle_in = idle_sat;
                        if (idle_sat >= cfg.timeout_ticks) begin
                           restart = 1'b1;
                        end
                     end
                  end
                  ufrm_pkg::KIND_DISCARD: begin
                     q_pop = 1'b1;
                     mb_full_in = 1'b0;
                     restart = 1'b1;
                  end
                  ufrm_pkg::KIND_READ: begin
                     if (slot_free) begin
                        q_pop = 1'b1;
                        mb_full_in = 1'b0;
                        if (mb_full_ff && mb_len_ff != '0) begin
                           ram_re = 1'b1;
                           rd_idx_in = '0;
                           state_in = ST_DRAIN;
                        end else begin
                           out_valid_in = 1'b1;
                           out_fvalid_in = mb_full_ff;
                           out_cmd_in = mb_full_ff ? mb_cmd_ff : 8'd0;
                           out_len_in = '0;
                           out_data_in = 8'd0;
                           out_idx_in = '0;
                           out_last_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_fvalid_in = 1'b1;
               out_cmd_in = mb_cmd_ff;
               out_len_in = mb_len_ff;
               out_data_in = ram_rdata;
               out_idx_in = ufrm_pkg::BYTE_INDEX_W'(rd_idx_ff);
               out_last_in = (rd_next == mb_len_ff);
               if (rd_next == mb_len_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re = 1'b1;
                  ram_raddr = {mb_bank_ff, rd_next[IW-1:0]};
                  rd_idx_in = rd_next[IW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         phase_in = restart_hdr ? PH_HUNT2 : PH_HUNT1;
         exp_len_in = '0;
         cmd_hold_in = 8'd0;
         fill_in = '0;
         sum_in = 8'd0;
         idle_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         state_ff <= ST_IDLE;
         exp_len_ff <= '0;
         cmd_hold_ff <= 8'd0;
         fill_ff <= '0;
         sum_ff <= 8'd0;
         idle_ff <= 16'd0;
         rx_bank_ff <= 1'b0;
         mb_bank_ff <= 1'b1;
         mb_full_ff <= 1'b0;
         mb_cmd_ff <= 8'd0;
         mb_len_ff <= '0;
         rd_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         state_ff <= state_in;
         exp_len_ff <= exp_len_in;
         cmd_hold_ff <= cmd_hold_in;
         fill_ff <= fill_in;
         sum_ff <= sum_in;
         idle_ff <= idle_in;
         rx_bank_ff <= rx_bank_in;
         mb_bank_ff <= mb_bank_in;
         mb_full_ff <= mb_full_in;
         mb_cmd_ff <= mb_cmd_in;
         mb_len_ff <= mb_len_in;
         rd_idx_ff <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
      out_fvalid_ff <= out_fvalid_in;
      out_cmd_ff <= out_cmd_in;
      out_len_ff <= out_len_in;
      out_data_ff <= out_data_in;
      out_idx_ff <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.frame_valid = out_fvalid_ff;
   assign rsp.command = out_cmd_ff;
   assign rsp.length = out_len_ff;
   assign rsp.payload_byte = out_data_ff;
   assign rsp.byte_index = out_idx_ff;
   assign rsp.last_item = out_last_ff;

   // The frame being received never writes the bank the mailbox owns.
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      mb_full_ff |-> (rx_bank_ff != mb_bank_ff))
      else $error("receive bank overlaps a full mailbox");

   // A drain only runs for a frame with payload.
   a_drain_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (mb_len_ff != '0))
      else $error("drain started for an empty payload");

   // While collecting payload the fill index stays below the frame length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (fill_ff < exp_len_ff))
      else $error("payload fill index ran past the frame length");

   // The queue is only popped when it holds an item.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

// File: verif/uart_frame_receiver_mailbox_core_tb.sv
// Self-checking testbench for the frame receiver mailbox core: directed table, then random traffic.
// Depends on ufrm_pkg, the channel interfaces in ufrm_channels.sv and the core RTL.
module uart_frame_receiver_mailbox_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 10;    // room for items that are still in the two-entry queue
   localparam int WATCHDOG_LIMIT = 1000; // quiet cycles before the run is ended
   localparam int ITEMS_PER_PHASE = 52;
   localparam int PHASE_COUNT = 5;
   localparam int REPORT_LIMIT = 10;

   localparam logic [7:0] RST_H1 = ufrm_pkg::HEADER_FIRST_RESET;
   localparam logic [7:0] RST_H2 = ufrm_pkg::HEADER_SECOND_RESET;

   // One result transaction as seen on the response channel.
   typedef struct packed {
      logic frame_valid;
      logic [7:0] command;
      logic [ufrm_pkg::LEN_W-1:0] length;
      logic [7:0] payload_byte;
      logic [ufrm_pkg::BYTE_INDEX_W-1:0] byte_index;
      logic last_item;
   } frame_beat_type;

   // One row of the directed table. Rows with a literal carry their expected result inline.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
      logic literal;
      frame_beat_type want;
   } stim_row_type;

   // Where the receive parser stands within a frame.
   typedef enum logic [2:0] {
      SEEK_H1,
      SEEK_H2,
      GET_LEN,
      GET_CMD,
      GET_DATA,
      GET_SUM
   } parse_state_type;

   localparam frame_beat_type NO_BEAT = '0;
   localparam frame_beat_type EMPTY_READ = '{1'b0, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1};
   localparam frame_beat_type ZERO_LEN_FF = '{1'b1, 8'hFF, 6'd0, 8'h00, 5'd0, 1'b1};

   // The directed part runs with the header bytes and timeout that reset leaves behind.
   localparam stim_row_type DIRECTED_ROWS[25] = '{
      // Read of an empty mailbox, then a tick while hunting, which does nothing.
      '{ufrm_pkg::CMD_READ, 8'h00, 1'b1, EMPTY_READ},
      '{ufrm_pkg::CMD_TICK, 8'hFF, 1'b0, NO_BEAT},
      // Zero-length frame with command 0xFF.
      '{ufrm_pkg::CMD_BYTE, RST_H1, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, RST_H2, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h00, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'hFF, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'hFF, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_READ, 8'h5A, 1'b1, ZERO_LEN_FF},
      // The read above emptied the mailbox.
      '{ufrm_pkg::CMD_READ, 8'hA5, 1'b1, EMPTY_READ},
      // Repeated first header byte, then one above the largest length.
      '{ufrm_pkg::CMD_BYTE, RST_H1, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, RST_H1, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, RST_H2, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h21, 1'b0, NO_BEAT},
      // One-byte frame with a bad checksum.
      '{ufrm_pkg::CMD_BYTE, RST_H1, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, RST_H2, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h01, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h00, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h80, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h00, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_READ, 8'h00, 1'b1, EMPTY_READ},
      // Largest length, then a discard.
      '{ufrm_pkg::CMD_BYTE, RST_H1, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, RST_H2, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_BYTE, 8'h20, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_DISCARD, 8'hFF, 1'b0, NO_BEAT},
      '{ufrm_pkg::CMD_READ, 8'hFF, 1'b1, EMPTY_READ}
   };

   logic clock;
   logic reset;

   ufrm_req_if req_if();
   ufrm_rsp_if rsp_if();
   ufrm_csr_if csr_if();

   uart_frame_receiver_mailbox_core dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_bus(csr_if)
   );

   // Private copy of the block's registers and state, advanced once per accepted request.
   ufrm_pkg::cfg_type cur_cfg;
   parse_state_type parse_state;
   logic [ufrm_pkg::LEN_W-1:0] want_len;
   logic [7:0] cmd_hold;
   logic [ufrm_pkg::LEN_W-1:0] fill_count;
   logic [7:0] run_sum;
   logic [15:0] idle_ticks;
   logic [7:0] rx_bytes[ufrm_pkg::MAX_PAYLOAD];
   logic mb_full;
   logic [7:0] mb_cmd;
   logic [ufrm_pkg::LEN_W-1:0] mb_len;
   logic [7:0] mb_bytes[ufrm_pkg::MAX_PAYLOAD];

   frame_beat_type fresh_beats[$];  // results caused by the request just accepted
   frame_beat_type beats_due[$];    // results still owed by the block, oldest first

   bit steady;                   // when set, neither side inserts gaps
   int requests_sent;
   int beats_seen;
   int mismatches;
   int frames_stored;
   int frames_dropped;
   int bad_sums;
   int timeouts;
   int reg_setups;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap lengths: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic string beat_text(frame_beat_type b);
      return $sformatf("valid=%0b cmd=%02h len=%0d byte=%02h idx=%0d last=%0b",
                       b.frame_valid, b.command, b.length, b.payload_byte, b.byte_index,
                       b.last_item);
   endfunction

   // Drops any partial frame. A byte that caused the restart may itself open a new frame.
   task automatic parser_restart(input bit as_header);
      parse_state = as_header ? SEEK_H2 : SEEK_H1;
      want_len = '0;
      cmd_hold = '0;
      fill_count = '0;
      run_sum = '0;
      idle_ticks = '0;
   endtask

   // Advances the private copy by one request and collects the results it causes.
   task automatic mailbox_model_step(input logic [1:0] cmd, input logic [7:0] b);
      case (cmd)
         ufrm_pkg::CMD_BYTE: begin
            case (parse_state)
               SEEK_H1: begin
                  if (b == cur_cfg.header_first) parse_state = SEEK_H2;
               end
               SEEK_H2: begin
                  if (b == cur_cfg.header_second) parse_state = GET_LEN;
                  else parser_restart(b == cur_cfg.header_first);
               end
               GET_LEN: begin
                  // An over-length byte restarts the hunt, but may itself be a first header.
                  if (b > ufrm_pkg::LEN_LIMIT) begin
                     parser_restart(b == cur_cfg.header_first);
                  end else begin
                     want_len = b[ufrm_pkg::LEN_W-1:0];
                     fill_count = '0;
                     run_sum = b;
                     parse_state = GET_CMD;
                  end
               end
               GET_CMD: begin
                  cmd_hold = b;
                  run_sum = run_sum + b;
                  parse_state = (want_len == 0) ? GET_SUM : GET_DATA;
               end
               GET_DATA: begin
                  rx_bytes[fill_count] = b;
                  run_sum = run_sum + b;
                  fill_count = fill_count + 1'b1;
                  if (fill_count >= want_len) parse_state = GET_SUM;
               end
               GET_SUM: begin
                  // The checksum byte is never taken as a header byte, good or bad.
                  if (b == run_sum) begin
                     if (!mb_full) begin
                        mb_cmd = cmd_hold;
                        mb_len = want_len;
                        for (int i = 0; i < want_len; i++) mb_bytes[i] = rx_bytes[i];
                        mb_full = 1'b1;
                        frames_stored++;
                     end else begin
                        frames_dropped++;
                     end
                  end else begin
                     bad_sums++;
                  end
                  parser_restart(1'b0);
               end
               default: parser_restart(1'b0);
            endcase
            idle_ticks = '0;
         end
         ufrm_pkg::CMD_TICK: begin
            if (parse_state != SEEK_H1) begin
               if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 1'b1;
               if (idle_ticks >= cur_cfg.timeout_ticks) begin
                  timeouts++;
                  parser_restart(1'b0);
               end
            end
         end
         ufrm_pkg::CMD_DISCARD: begin
            mb_full = 1'b0;
            parser_restart(1'b0);
         end
         default: begin
            // A read: one result for an empty mailbox or an empty payload, else one per byte.
            if (!mb_full) begin
               fresh_beats.push_back(EMPTY_READ);
            end else begin
               mb_full = 1'b0;
               if (mb_len == 0) begin
                  fresh_beats.push_back('{1'b1, mb_cmd, 6'd0, 8'h00, 5'd0, 1'b1});
               end else begin
                  for (int i = 0; i < mb_len; i++)
                     fresh_beats.push_back('{1'b1, mb_cmd, mb_len, mb_bytes[i],
                                            ufrm_pkg::BYTE_INDEX_W'(i), i == mb_len - 1});
               end
            end
         end
      endcase
   endtask

   // Drops valid between requests for a gap set by n; with n zero the next request follows back to back.
   task automatic pause_sender(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Offers one request, waits for its transaction, then records what it should produce.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic literal,
                            input frame_beat_type want);
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.data_byte <= b;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      requests_sent++;
      fresh_beats.delete();
      mailbox_model_step(cmd, b);
      if (literal) begin
         beats_due.push_back(want);
      end else begin
         foreach (fresh_beats[i]) beats_due.push_back(fresh_beats[i]);
      end
      pause_sender(pick_gap());
   endtask

   // A received byte, now and then preceded by a tick so that frames see idle time.
   task automatic feed_byte(input logic [7:0] b);
      if ($urandom_range(19) == 0) send_item(ufrm_pkg::CMD_TICK, 8'($urandom), 1'b0, NO_BEAT);
      send_item(ufrm_pkg::CMD_BYTE, b, 1'b0, NO_BEAT);
   endtask

   task automatic send_frame(input int len, input logic [7:0] opcode, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      sum = 8'(len) + opcode;
      feed_byte(cur_cfg.header_first);
      feed_byte(cur_cfg.header_second);
      feed_byte(8'(len));
      feed_byte(opcode);
      repeat (len) begin
         b = 8'($urandom);
         sum = sum + b;
         feed_byte(b);
      end
      feed_byte(good_sum ? sum : sum ^ (8'd1 << $urandom_range(7)));
   endtask

   // Stops sending until every owed result has arrived and the request queue has emptied.
   task automatic wait_for_drain();
      pause_sender(1);
      while (beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ufrm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ufrm_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata <= value;
      @(posedge clock);
      while (!(csr_if.valid && csr_if.ready)) @(posedge clock);
      case (idx)
         ufrm_pkg::REG_HEADER_FIRST: cur_cfg.header_first = value[7:0];
         ufrm_pkg::REG_HEADER_SECOND: cur_cfg.header_second = value[7:0];
         ufrm_pkg::REG_TIMEOUT_TICKS: cur_cfg.timeout_ticks = value;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // The receiver raises ready, then may hold it low for a random gap chosen by pick_gap.
   initial begin : response_pacing
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            hold_left = pick_gap();
         end
      end
   end

   // Every result transaction is checked against the oldest owed result.
   always @(posedge clock) begin
      frame_beat_type got;
      frame_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.frame_valid, rsp_if.command, rsp_if.length, rsp_if.payload_byte,
                 rsp_if.byte_index, rsp_if.last_item};
         beats_seen++;
         if (beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with nothing owed: %s", $realtime, beat_text(got));
         end else begin
            want = beats_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: result %0d differs", $realtime, beats_seen);
                  $display("   expected %s", beat_text(want));
                  $display("   actual   %s", beat_text(got));
               end
            end
         end
      end
   end

   // Ends the run if no channel completes a transaction for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no transaction for %0d cycles, %0d results still owed", $realtime,
               quiet, beats_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      ufrm_pkg::cfg_type plan;
      int phase_end;
      int pick;
      int len;
      int ticks;

      // Every input gets a known value before the first edge.
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd = ufrm_pkg::CMD_BYTE;
      req_if.data_byte = 8'h00;
      csr_if.valid = 1'b0;
      csr_if.reg_index = ufrm_pkg::REG_HEADER_FIRST;
      csr_if.wdata = '0;
      steady = 1'b0;
      requests_sent = 0;
      beats_seen = 0;
      mismatches = 0;
      frames_stored = 0;
      frames_dropped = 0;
      bad_sums = 0;
      timeouts = 0;
      reg_setups = 0;

      // State that reset leaves behind in the block.
      cur_cfg = '{RST_H1, RST_H2, ufrm_pkg::TIMEOUT_TICKS_RESET};
      parser_restart(1'b0);
      mb_full = 1'b0;
      mb_cmd = '0;
      mb_len = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty reads, a zero-length frame, restarts and a discard.
      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].literal,
                   DIRECTED_ROWS[i].want);

      // Random part: one phase per register setup, each written only while the block is idle.
      // The setups cover the reset values, both header extremes, the shortest and longest
      // timeout, equal header bytes, and a first header byte that is also an illegal length.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: plan = '{RST_H1, RST_H2, ufrm_pkg::TIMEOUT_TICKS_RESET};
            1: plan = '{8'h00, 8'hFF, 16'd1};
            2: plan = '{8'hFF, 8'h00, 16'hFFFF};
            3: plan = '{8'h5A, 8'h5A, 16'd3};
            default: plan = '{8'($urandom_range(255, 33)), 8'($urandom_range(255)),
                              16'($urandom_range(40, 2))};
         endcase
         wait_for_drain();
         write_reg(ufrm_pkg::REG_HEADER_FIRST, ufrm_pkg::CSR_DATA_W'(plan.header_first));
         write_reg(ufrm_pkg::REG_HEADER_SECOND, ufrm_pkg::CSR_DATA_W'(plan.header_second));
         write_reg(ufrm_pkg::REG_TIMEOUT_TICKS, plan.timeout_ticks);
         reg_setups++;
         steady = (p == 3);

         phase_end = requests_sent + ITEMS_PER_PHASE;
         while (requests_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               // Frame, its checksum good nine times in ten: mostly short, some medium, a few at the largest length.
               pick = $urandom_range(99);
               if (pick < 70) len = $urandom_range(6);
               else if (pick < 88) len = $urandom_range(31, 7);
               else len = ufrm_pkg::MAX_PAYLOAD;
               send_frame(len, 8'($urandom), $urandom_range(9) != 0);
            end else if (pick < 72) begin
               send_item(ufrm_pkg::CMD_READ, 8'($urandom), 1'b0, NO_BEAT);
            end else if (pick < 76) begin
               send_item(ufrm_pkg::CMD_DISCARD, 8'($urandom), 1'b0, NO_BEAT);
            end else if (pick < 86) begin
               // Line noise: stray bytes and ticks.
               repeat ($urandom_range(4, 1)) begin
                  if ($urandom_range(1) == 0)
                     send_item(ufrm_pkg::CMD_TICK, 8'($urandom), 1'b0, NO_BEAT);
                  else
                     send_item(ufrm_pkg::CMD_BYTE, 8'($urandom), 1'b0, NO_BEAT);
               end
            end else begin
               // Broken frames that must send the parser back to its hunt, or a stray header before a good frame.
               case ($urandom_range(3))
                  0: begin
                     feed_byte(cur_cfg.header_first);
                     feed_byte(cur_cfg.header_second ^ 8'($urandom_range(255, 1)));
                  end
                  1: begin
                     feed_byte(cur_cfg.header_first);
                     feed_byte(cur_cfg.header_second);
                     if (cur_cfg.header_first > ufrm_pkg::LEN_LIMIT && $urandom_range(1) == 0)
                        feed_byte(cur_cfg.header_first);
                     else
                        feed_byte(8'($urandom_range(255, 33)));
                  end
                  2: begin
                     // Truncated frame left to time out when the timeout is short enough.
                     len = $urandom_range(8, 1);
                     feed_byte(cur_cfg.header_first);
                     feed_byte(cur_cfg.header_second);
                     feed_byte(8'(len));
                     feed_byte(8'($urandom));
                     repeat ($urandom_range(len - 1)) feed_byte(8'($urandom));
                     ticks = (cur_cfg.timeout_ticks <= 120) ? cur_cfg.timeout_ticks : 5;
                     repeat (ticks) send_item(ufrm_pkg::CMD_TICK, 8'($urandom), 1'b0, NO_BEAT);
                  end
                  default: begin
                     feed_byte(cur_cfg.header_first);
                     send_frame($urandom_range(4), 8'($urandom), 1'b1);
                  end
               endcase
            end
            // Now and then the sender waits for the mailbox traffic to drain completely.
            if ($urandom_range(39) == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      $display("covered %0d requests and %0d result transactions over %0d register setups",
               requests_sent, beats_seen, reg_setups);
      $display("frames stored %0d, dropped while full %0d, bad checksum %0d, timeouts %0d",
               frames_stored, frames_dropped, bad_sums, timeouts);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d result mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
